### rtl/mdt_pkg.sv
// Package for the most-recently-used device table.
// Holds the entry and result types and the operation, event, and state codes.
// It has no dependencies and is used by every module of the table.
package mdt_pkg;

    typedef enum logic [2:0] {
        KIND_ENSURE = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_GET    = 3'd2,
        KIND_SET    = 3'd3,
        KIND_LIST   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CREATE = 2'd1,
        EV_DELETE = 2'd2,
        EV_UPDATE = 2'd3
    } event_t;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NOT_FOUND = 1'b1;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_LOAD,
        CELL_WRITE_CFG
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_INSERT,
        S_LIST
    } state_t;

    typedef struct packed {
        logic [7:0]  addr_type;
        logic [47:0] addr;
        logic [63:0] cfg;
    } entry_t;

    typedef struct packed {
        logic        status;
        event_t      event_res;
        logic [47:0] event_addr;
        logic [7:0]  event_addr_type;
        logic [63:0] config_out;
        logic [47:0] list_addr;
        logic [7:0]  list_addr_type;
        logic [3:0]  entry_count;
        logic        save_request;
        logic        last;
    } result_t;

endpackage

### rtl/mdt_cell.sv
// One cell of the table chain: holds a single key and config word.
// Takes its neighbor's entry, a loaded entry, or a new config word on command.
// Depends on mdt_pkg.
module mdt_cell
(
    input  logic                  clk,
    input  mdt_pkg::cell_cmd_t    cmd,
    input  mdt_pkg::entry_t       left_entry,
    input  mdt_pkg::entry_t       right_entry,
    input  mdt_pkg::entry_t       load_entry,
    input  logic [63:0]           cfg_in,
    output mdt_pkg::entry_t       entry
);

    mdt_pkg::entry_t entry_reg;
    mdt_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd)
            mdt_pkg::CELL_HOLD:       entry_next = entry_reg;
            mdt_pkg::CELL_TAKE_LEFT:  entry_next = left_entry;
            mdt_pkg::CELL_TAKE_RIGHT: entry_next = right_entry;
            mdt_pkg::CELL_LOAD:       entry_next = load_entry;
            mdt_pkg::CELL_WRITE_CFG:  entry_next.cfg = cfg_in;
            default:                  entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

### rtl/mru_device_table_top.sv
// Top level of the most-recently-used device table, built as a ring of mdt_cell instances.
// Contains the request sequencer and the result register; depends on mdt_pkg and mdt_cell.
//
// The table keeps up to TABLE_ENTRIES device keys, front first, in a ring of cells.
// Every lookup rotates the ring once around, so each stored entry passes the front cell
// where it is compared with the key; ensure, delete, get and set therefore search the
// whole ring before the decide state applies and reports (an ensure that evicts the last
// entry reports the eviction and then the creation from the insert state). A list of a
// non-empty table also rotates the ring once, giving one result per cycle while the output
// is not stalled; a list of an empty table gives one result and no rotation, and an unused
// kind skips the search. A new transaction is accepted only when the previous one is
// finished; a result may still be waiting on the output then.
module mru_device_table_top
#(
    parameter int TABLE_ENTRIES = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [47:0] addr,
    input  logic [7:0]  addr_type,
    input  logic        save,
    input  logic [63:0] config_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [1:0]  event_res,
    output logic [47:0] event_addr,
    output logic [7:0]  event_addr_type,
    output logic [63:0] config_out,
    output logic [47:0] list_addr,
    output logic [7:0]  list_addr_type,
    output logic [3:0]  entry_count,
    output logic        save_request,
    output logic        last
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    function automatic logic [3:0] low4(input logic [CNT_W-1:0] v);
        logic [CNT_W+3:0] w;
        w = {4'b0000, v};
        return w[3:0];
    endfunction

    mdt_pkg::state_t   state_reg, state_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              found_reg, found_next;
    mdt_pkg::entry_t   hold_reg, hold_next;
    mdt_pkg::kind_t    kind_reg, kind_next;
    logic [47:0]       addr_reg, addr_next;
    logic [7:0]        addr_type_reg, addr_type_next;
    logic              save_reg, save_next;
    logic [63:0]       cfg_reg, cfg_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    mdt_pkg::result_t  res_reg, res_next;

    mdt_pkg::entry_t    cell_entry [TABLE_ENTRIES];
    mdt_pkg::cell_cmd_t cell_cmd   [TABLE_ENTRIES];
    mdt_pkg::entry_t    load_entry;

    logic rotate;
    logic move_front;
    logic do_insert;
    logic shift_del;
    logic write_cfg;
    logic out_free;
    logic front_match;
    logic step_in_count;
    logic step_is_end;
    logic list_emit;
    logic list_last;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            mdt_cell u_cell
            (
                .clk         (clk),
                .cmd         (cell_cmd[g]),
                .left_entry  (cell_entry[(g + TABLE_ENTRIES - 1) % TABLE_ENTRIES]),
                .right_entry (cell_entry[(g + 1) % TABLE_ENTRIES]),
                .load_entry  (load_entry),
                .cfg_in      (cfg_reg),
                .entry       (cell_entry[g])
            );
        end
    endgenerate

    assign out_free      = !out_valid_reg || !out_stall;
    assign front_match   = (cell_entry[0].addr == addr_reg) &&
                           (cell_entry[0].addr_type == addr_type_reg);
    assign step_in_count = CNT_W'(step_reg) < count_reg;
    assign step_is_end   = step_reg == IDX_W'(TABLE_ENTRIES - 1);
    assign list_emit     = step_in_count || ((count_reg == '0) && (step_reg == '0));
    assign list_last     = ((CNT_W'(step_reg) + CNT_W'(1)) == count_reg) ||
                           (count_reg == '0);
    assign load_entry    = move_front ? hold_reg : mdt_pkg::entry_t'{addr_type: addr_type_reg,
                                                                  addr: addr_reg, cfg: 64'd0};

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        hold_next      = hold_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        addr_type_next = addr_type_reg;
        save_next      = save_reg;
        cfg_next       = cfg_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;
        rotate         = 1'b0;
        move_front     = 1'b0;
        do_insert      = 1'b0;
        shift_del      = 1'b0;
        write_cfg      = 1'b0;
        in_stall       = state_reg != mdt_pkg::S_IDLE;

        unique case (state_reg)
            mdt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next      = mdt_pkg::kind_t'(kind);
                    addr_next      = addr;
                    addr_type_next = addr_type;
                    save_next      = save;
                    cfg_next       = config_in;
                    step_next      = '0;
                    found_next     = 1'b0;
                    case (mdt_pkg::kind_t'(kind)) inside
                        mdt_pkg::KIND_LIST:
                            state_next = mdt_pkg::S_LIST;
                        mdt_pkg::KIND_ENSURE, mdt_pkg::KIND_DELETE,
                        mdt_pkg::KIND_GET, mdt_pkg::KIND_SET:
                            state_next = mdt_pkg::S_SCAN;
                        default:
                            state_next = mdt_pkg::S_DECIDE;
                    endcase
                end
            end

            mdt_pkg::S_SCAN:
            begin
                rotate = 1'b1;
                if (!found_reg && step_in_count && front_match)
                begin
                    found_next = 1'b1;
                    idx_next   = step_reg;
                    hold_next  = cell_entry[0];
                end
                if (step_is_end)
                begin
                    step_next  = '0;
                    state_next = mdt_pkg::S_DECIDE;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end

            mdt_pkg::S_DECIDE:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    res_next             = '0;
                    res_next.entry_count = low4(count_reg);
                    res_next.last        = 1'b1;
                    state_next           = mdt_pkg::S_IDLE;
                    case (kind_reg)
                        mdt_pkg::KIND_ENSURE:
                        begin
                            if (found_reg)
                            begin
                                if (idx_reg != '0)
                                begin
                                    move_front            = 1'b1;
                                    res_next.save_request = save_reg;
                                end
                            end
                            else if (count_reg == CNT_W'(TABLE_ENTRIES))
                            begin
                                count_next               = CNT_W'(TABLE_ENTRIES - 1);
                                res_next.event_res       = mdt_pkg::EV_DELETE;
                                res_next.event_addr      = cell_entry[TABLE_ENTRIES-1].addr;
                                res_next.event_addr_type =
                                    cell_entry[TABLE_ENTRIES-1].addr_type;
                                res_next.entry_count     = low4(CNT_W'(TABLE_ENTRIES - 1));
                                res_next.last            = 1'b0;
                                state_next               = mdt_pkg::S_INSERT;
                            end
                            else
                            begin
                                do_insert                = 1'b1;
                                count_next               = count_reg + CNT_W'(1);
                                res_next.event_res       = mdt_pkg::EV_CREATE;
                                res_next.event_addr      = addr_reg;
                                res_next.event_addr_type = addr_type_reg;
                                res_next.entry_count     = low4(count_reg + CNT_W'(1));
                                res_next.save_request    = save_reg;
                            end
                        end
                        mdt_pkg::KIND_DELETE:
                        begin
                            if (found_reg)
                            begin
                                shift_del                = 1'b1;
                                count_next               = count_reg - CNT_W'(1);
                                res_next.event_res       = mdt_pkg::EV_DELETE;
                                res_next.event_addr      = addr_reg;
                                res_next.event_addr_type = addr_type_reg;
                                res_next.entry_count     = low4(count_reg - CNT_W'(1));
                                res_next.save_request    = 1'b1;
                            end
                            else
                            begin
                                res_next.status = mdt_pkg::STATUS_NOT_FOUND;
                            end
                        end
                        mdt_pkg::KIND_GET:
                        begin
                            if (found_reg)
                                res_next.config_out = hold_reg.cfg;
                            else
                                res_next.status = mdt_pkg::STATUS_NOT_FOUND;
                        end
                        mdt_pkg::KIND_SET:
                        begin
                            if (!found_reg)
                            begin
                                res_next.status = mdt_pkg::STATUS_NOT_FOUND;
                            end
                            else if (hold_reg.cfg != cfg_reg)
                            begin
                                write_cfg                = 1'b1;
                                res_next.event_res       = mdt_pkg::EV_UPDATE;
                                res_next.event_addr      = addr_reg;
                                res_next.event_addr_type = addr_type_reg;
                                res_next.save_request    = save_reg;
                            end
                        end
                        default:
                        begin
                            res_next.status = mdt_pkg::STATUS_OK;
                        end
                    endcase
                end
            end

            mdt_pkg::S_INSERT:
            begin
                if (out_free)
                begin
                    do_insert                = 1'b1;
                    count_next               = count_reg + CNT_W'(1);
                    out_valid_next           = 1'b1;
                    res_next                 = '0;
                    res_next.event_res       = mdt_pkg::EV_CREATE;
                    res_next.event_addr      = addr_reg;
                    res_next.event_addr_type = addr_type_reg;
                    res_next.entry_count     = low4(count_reg + CNT_W'(1));
                    res_next.save_request    = save_reg;
                    res_next.last            = 1'b1;
                    state_next               = mdt_pkg::S_IDLE;
                end
            end

            mdt_pkg::S_LIST:
            begin
                if (!list_emit || out_free)
                begin
                    if (list_emit)
                    begin
                        out_valid_next       = 1'b1;
                        res_next             = '0;
                        res_next.entry_count = low4(count_reg);
                        res_next.last        = list_last;
                        if (count_reg != '0)
                        begin
                            res_next.list_addr      = cell_entry[0].addr;
                            res_next.list_addr_type = cell_entry[0].addr_type;
                        end
                    end
                    if (count_reg == '0)
                    begin
                        state_next = mdt_pkg::S_IDLE;
                    end
                    else
                    begin
                        rotate = 1'b1;
                        if (step_is_end)
                        begin
                            step_next  = '0;
                            state_next = mdt_pkg::S_IDLE;
                        end
                        else
                        begin
                            step_next = step_reg + IDX_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = mdt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int j = 0; j < TABLE_ENTRIES; j++)
        begin
            cell_cmd[j] = mdt_pkg::CELL_HOLD;
            if (rotate)
            begin
                cell_cmd[j] = mdt_pkg::CELL_TAKE_RIGHT;
            end
            else if (move_front)
            begin
                if (j == 0)
                    cell_cmd[j] = mdt_pkg::CELL_LOAD;
                else if (IDX_W'(j) <= idx_reg)
                    cell_cmd[j] = mdt_pkg::CELL_TAKE_LEFT;
            end
            else if (do_insert)
            begin
                if (j == 0)
                    cell_cmd[j] = mdt_pkg::CELL_LOAD;
                else
                    cell_cmd[j] = mdt_pkg::CELL_TAKE_LEFT;
            end
            else if (shift_del)
            begin
                if ((IDX_W'(j) >= idx_reg) && (j < TABLE_ENTRIES - 1))
                    cell_cmd[j] = mdt_pkg::CELL_TAKE_RIGHT;
            end
            else if (write_cfg)
            begin
                if (IDX_W'(j) == idx_reg)
                    cell_cmd[j] = mdt_pkg::CELL_WRITE_CFG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mdt_pkg::S_IDLE;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        hold_reg      <= hold_next;
        kind_reg      <= kind_next;
        addr_reg      <= addr_next;
        addr_type_reg <= addr_type_next;
        save_reg      <= save_next;
        cfg_reg       <= cfg_next;
        res_reg       <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = res_reg.status;
    assign event_res       = res_reg.event_res;
    assign event_addr      = res_reg.event_addr;
    assign event_addr_type = res_reg.event_addr_type;
    assign config_out      = res_reg.config_out;
    assign list_addr       = res_reg.list_addr;
    assign list_addr_type  = res_reg.list_addr_type;
    assign entry_count     = res_reg.entry_count;
    assign save_request    = res_reg.save_request;
    assign last            = res_reg.last;

endmodule

### sim/tb_mru_device_table_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the most-recently-used device table top level.
// Depends on mdt_pkg and mru_device_table_top; it keeps its own copy of the table
// and checks every result transaction.

module tb_mru_device_table_top;

    localparam int TABLE_ENTRIES = 8;
    localparam int SETTLE_CYCLES = TABLE_ENTRIES + 6;
    localparam int POOL_SIZE = 12;
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam logic [55:0] KEY_ZERO = '0;
    localparam logic [55:0] KEY_ONES = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] kind = '0;
    logic [47:0] addr = '0;
    logic [7:0] addr_type = '0;
    logic save = 1'b0;
    logic [63:0] config_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic status;
    logic [1:0] event_res;
    logic [47:0] event_addr;
    logic [7:0] event_addr_type;
    logic [63:0] config_out;
    logic [47:0] list_addr;
    logic [7:0] list_addr_type;
    logic [3:0] entry_count;
    logic save_request;
    logic last;

    logic [55:0] table_key [TABLE_ENTRIES];
    logic [63:0] table_cfg [TABLE_ENTRIES];
    int table_fill = 0;
    mdt_pkg::result_t expected_results [$];
    logic [55:0] key_pool [POOL_SIZE];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int mismatch_count = 0;

    mru_device_table_top #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .addr(addr),
        .addr_type(addr_type),
        .save(save),
        .config_in(config_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .event_res(event_res),
        .event_addr(event_addr),
        .event_addr_type(event_addr_type),
        .config_out(config_out),
        .list_addr(list_addr),
        .list_addr_type(list_addr_type),
        .entry_count(entry_count),
        .save_request(save_request),
        .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int find_entry(logic [55:0] key);
        for (int i = 0; i < table_fill; i++)
        begin
            if (table_key[i] == key)
                return i;
        end
        return TABLE_ENTRIES;
    endfunction

    function automatic mdt_pkg::result_t make_result(logic st, mdt_pkg::event_t ev,
                                                     logic [55:0] ev_key, logic [63:0] cfg,
                                                     logic [55:0] list_key,
                                                     logic save_req, logic is_last);
        mdt_pkg::result_t r;
        r.status = st;
        r.event_res = ev;
        r.event_addr = ev_key[47:0];
        r.event_addr_type = ev_key[55:48];
        r.config_out = cfg;
        r.list_addr = list_key[47:0];
        r.list_addr_type = list_key[55:48];
        r.entry_count = table_fill[3:0];
        r.save_request = save_req;
        r.last = is_last;
        return r;
    endfunction

    function automatic void predict_request(logic [2:0] op, logic [55:0] key,
                                            logic save_req, logic [63:0] cfg);
        int idx;
        logic [55:0] moved_key;
        logic [63:0] moved_cfg;
        idx = find_entry(key);
        case (op)
            mdt_pkg::KIND_ENSURE:
            begin
                if (idx == 0)
                begin
                    expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                           mdt_pkg::EV_NONE, '0, '0, '0,
                                                           1'b0, 1'b1));
                end
                else if (idx < TABLE_ENTRIES)
                begin
                    moved_key = table_key[idx];
                    moved_cfg = table_cfg[idx];
                    for (int i = idx; i > 0; i--)
                    begin
                        table_key[i] = table_key[i - 1];
                        table_cfg[i] = table_cfg[i - 1];
                    end
                    table_key[0] = moved_key;
                    table_cfg[0] = moved_cfg;
                    expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                           mdt_pkg::EV_NONE, '0, '0, '0,
                                                           save_req, 1'b1));
                end
                else
                begin
                    if (table_fill >= TABLE_ENTRIES)
                    begin
                        table_fill = TABLE_ENTRIES - 1;
                        expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                               mdt_pkg::EV_DELETE,
                                                               table_key[TABLE_ENTRIES - 1],
                                                               '0, '0, 1'b0, 1'b0));
                    end
                    for (int i = table_fill; i > 0; i--)
                    begin
                        table_key[i] = table_key[i - 1];
                        table_cfg[i] = table_cfg[i - 1];
                    end
                    table_key[0] = key;
                    table_cfg[0] = '0;
                    table_fill++;
                    expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                           mdt_pkg::EV_CREATE, key, '0, '0,
                                                           save_req, 1'b1));
                end
            end
            mdt_pkg::KIND_DELETE:
            begin
                if (idx >= TABLE_ENTRIES)
                begin
                    expected_results.push_back(make_result(mdt_pkg::STATUS_NOT_FOUND,
                                                           mdt_pkg::EV_NONE, '0, '0, '0,
                                                           1'b0, 1'b1));
                end
                else
                begin
                    for (int i = idx; i + 1 < table_fill; i++)
                    begin
                        table_key[i] = table_key[i + 1];
                        table_cfg[i] = table_cfg[i + 1];
                    end
                    table_fill--;
                    expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                           mdt_pkg::EV_DELETE, key, '0, '0,
                                                           1'b1, 1'b1));
                end
            end
            mdt_pkg::KIND_GET:
            begin
                if (idx >= TABLE_ENTRIES)
                    expected_results.push_back(make_result(mdt_pkg::STATUS_NOT_FOUND,
                                                           mdt_pkg::EV_NONE, '0, '0, '0,
                                                           1'b0, 1'b1));
                else
                    expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                           mdt_pkg::EV_NONE, '0,
                                                           table_cfg[idx], '0, 1'b0, 1'b1));
            end
            mdt_pkg::KIND_SET:
            begin
                if (idx >= TABLE_ENTRIES)
                begin
                    expected_results.push_back(make_result(mdt_pkg::STATUS_NOT_FOUND,
                                                           mdt_pkg::EV_NONE, '0, '0, '0,
                                                           1'b0, 1'b1));
                end
                else if (table_cfg[idx] != cfg)
                begin
                    table_cfg[idx] = cfg;
                    expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                           mdt_pkg::EV_UPDATE, key, '0, '0,
                                                           save_req, 1'b1));
                end
                else
                begin
                    expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                           mdt_pkg::EV_NONE, '0, '0, '0,
                                                           1'b0, 1'b1));
                end
            end
            mdt_pkg::KIND_LIST:
            begin
                if (table_fill == 0)
                begin
                    expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                           mdt_pkg::EV_NONE, '0, '0, '0,
                                                           1'b0, 1'b1));
                end
                for (int i = 0; i < table_fill; i++)
                begin
                    expected_results.push_back(make_result(mdt_pkg::STATUS_OK,
                                                           mdt_pkg::EV_NONE, '0, '0,
                                                           table_key[i], 1'b0,
                                                           i == table_fill - 1));
                end
            end
            default:
            begin
                expected_results.push_back(make_result(mdt_pkg::STATUS_OK, mdt_pkg::EV_NONE,
                                                       '0, '0, '0, 1'b0, 1'b1));
            end
        endcase
    endfunction

    function automatic string describe(mdt_pkg::result_t r);
        return {$sformatf("st=%0d ev=%0d ev_key=%02h_%012h cfg=%016h ",
                          r.status, r.event_res, r.event_addr_type, r.event_addr,
                          r.config_out),
                $sformatf("list=%02h_%012h cnt=%0d save=%0d last=%0d",
                          r.list_addr_type, r.list_addr, r.entry_count,
                          r.save_request, r.last)};
    endfunction

    function automatic string field_diffs(mdt_pkg::result_t e, mdt_pkg::result_t a);
        string s;
        s = "";
        if (a.status !== e.status) s = {s, " status"};
        if (a.event_res !== e.event_res) s = {s, " event_res"};
        if (a.event_addr !== e.event_addr) s = {s, " event_addr"};
        if (a.event_addr_type !== e.event_addr_type) s = {s, " event_addr_type"};
        if (a.config_out !== e.config_out) s = {s, " config_out"};
        if (a.list_addr !== e.list_addr) s = {s, " list_addr"};
        if (a.list_addr_type !== e.list_addr_type) s = {s, " list_addr_type"};
        if (a.entry_count !== e.entry_count) s = {s, " entry_count"};
        if (a.save_request !== e.save_request) s = {s, " save_request"};
        if (a.last !== e.last) s = {s, " last"};
        return s;
    endfunction

    task automatic note_mismatch(input string what);
        if (mismatch_count < 10)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        mdt_pkg::result_t seen;
        mdt_pkg::result_t want;
        string diffs;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {status, event_res, event_addr, event_addr_type, config_out, list_addr,
                    list_addr_type, entry_count, save_request, last};
            if (expected_results.size() == 0)
            begin
                note_mismatch({"unexpected result ", describe(seen)});
            end
            else
            begin
                want = expected_results.pop_front();
                diffs = field_diffs(want, seen);
                if (diffs != "")
                    note_mismatch({"field(s)", diffs, "\n  expected ", describe(want),
                                   "\n  actual   ", describe(seen)});
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_request(logic [2:0] op, logic [55:0] key, logic save_req,
                                logic [63:0] cfg);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        kind <= op;
        addr <= key[47:0];
        addr_type <= key[55:48];
        save <= save_req;
        config_in <= cfg;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_request(op, key, save_req, cfg);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_request();
        int pick;
        int idx;
        logic [2:0] op;
        logic [55:0] key;
        logic [63:0] cfg;
        logic [63:0] wide;
        pick = $urandom_range(99);
        wide = {$urandom, $urandom};
        key = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (table_fill > 0 && $urandom_range(9) < 3)
            key = table_key[$urandom_range(table_fill - 1)];
        if (pick < 35)
            op = mdt_pkg::KIND_ENSURE;
        else if (pick < 48)
            op = mdt_pkg::KIND_DELETE;
        else if (pick < 63)
            op = mdt_pkg::KIND_GET;
        else if (pick < 85)
            op = mdt_pkg::KIND_SET;
        else if (pick < 95)
            op = mdt_pkg::KIND_LIST;
        else
        begin
            idx = $urandom_range(KIND_UNUSED);
            op = idx[2:0];
            key = wide[55:0];
        end
        case ($urandom_range(3))
            0: cfg = '0;
            1: cfg = '1;
            2: cfg = {$urandom, $urandom};
            default:
            begin
                idx = find_entry(key);
                cfg = (idx < TABLE_ENTRIES) ? table_cfg[idx] : {$urandom, $urandom};
            end
        endcase
        send_request(op, key, wide[63], cfg);
    endtask

    task automatic test_empty_table();
        send_request(mdt_pkg::KIND_LIST, KEY_ZERO, 1'b0, '0);
        send_request(mdt_pkg::KIND_GET, KEY_ONES, 1'b0, '0);
        send_request(mdt_pkg::KIND_SET, KEY_ONES, 1'b1, '1);
        send_request(mdt_pkg::KIND_DELETE, KEY_ZERO, 1'b1, '0);
    endtask

    task automatic test_fill_and_evict();
        send_request(mdt_pkg::KIND_ENSURE, KEY_ZERO, 1'b1, '1);
        send_request(mdt_pkg::KIND_ENSURE, KEY_ONES, 1'b0, '0);
        for (int i = 0; i < TABLE_ENTRIES - 2; i++)
            send_request(mdt_pkg::KIND_ENSURE, key_pool[i], i[0], {$urandom, $urandom});
        send_request(mdt_pkg::KIND_ENSURE, key_pool[TABLE_ENTRIES - 2], 1'b1, '0);
        send_request(mdt_pkg::KIND_ENSURE, key_pool[TABLE_ENTRIES - 2], 1'b1, '0);
        send_request(mdt_pkg::KIND_ENSURE, KEY_ONES, 1'b1, '0);
    endtask

    task automatic test_config_word();
        send_request(mdt_pkg::KIND_SET, KEY_ONES, 1'b1, '1);
        send_request(mdt_pkg::KIND_SET, KEY_ONES, 1'b1, '1);
        send_request(mdt_pkg::KIND_GET, KEY_ONES, 1'b0, '0);
        send_request(mdt_pkg::KIND_SET, key_pool[0], 1'b0, {$urandom, $urandom});
        send_request(mdt_pkg::KIND_GET, key_pool[0], 1'b1, '0);
    endtask

    task automatic test_delete_entry();
        send_request(mdt_pkg::KIND_DELETE, key_pool[2], 1'b0, '0);
        send_request(mdt_pkg::KIND_DELETE, KEY_ZERO, 1'b1, '0);
        send_request(mdt_pkg::KIND_LIST, KEY_ZERO, 1'b0, '0);
    endtask

    task automatic test_unused_kind();
        send_request(KIND_UNUSED, KEY_ONES, 1'b1, '1);
    endtask

    task automatic test_output_holdoff();
        hold_left = 60;
        repeat (6) random_request();
        wait_for_drain();
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) random_request();
        wait_for_drain();
    endtask

    initial
    begin
        logic [63:0] wide;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            wide = {$urandom, $urandom};
            key_pool[i] = wide[55:0];
        end
        key_pool[1] = {~key_pool[0][55:48], key_pool[0][47:0]};
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 27;
        recv_stall_pct = 45;
        test_empty_table();
        test_fill_and_evict();
        test_config_word();
        test_delete_entry();
        test_unused_kind();
        wait_for_drain();
        test_output_holdoff();
        test_random_traffic(65, 27, 45);
        test_random_traffic(65, 45, 27);
        test_output_holdoff();
        test_random_traffic(65, 0, 0);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/mdt_pkg.sv
rtl/mdt_cell.sv
rtl/mru_device_table_top.sv
sim/tb_mru_device_table_top.sv
